/* design/mtt_pkg.sv */
// Shared types, constants and helper functions of the multiturn angle tracker.
`default_nettype none
package mtt_pkg;

    localparam int TURN_BITS  = 20;
    localparam int ANGLE_BITS = 12;
    localparam int TURN_W     = 20;
    localparam int TOT_W      = 32;
    localparam int GEAR_W     = 24;
    localparam int JNT_W      = 48;
    localparam int TS_W       = 32;
    localparam int OP_W       = 2;
    localparam int FRAC       = 8;
    localparam int AW         = 58;
    localparam int QM_W       = JNT_W + 1;
    localparam int REM_W      = TS_W + 1;
    localparam int CNT_W      = $clog2(AW);
    localparam int GIDX_W     = $clog2(GEAR_W);

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int RIDX_W     = ADDR_W - 2;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = OP_W;
    localparam int OUT_DATA_W = 168;

    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

    localparam logic [RIDX_W-1:0] REG_GEAR   = 1'd0;
    localparam logic [RIDX_W-1:0] REG_PRESET = 1'd1;

    localparam logic [GEAR_W-1:0] GEAR_RESET = 24'd65536;

    localparam logic signed [ANGLE_BITS:0] HALF_TURN = 13'sd2048;
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
    localparam logic [JNT_W-1:0] JNT_MAX = {1'b0, {(JNT_W-1){1'b1}}};
    localparam logic [JNT_W-1:0] JNT_MIN = {1'b1, {(JNT_W-1){1'b0}}};
    localparam logic [AW-1:0] ROUND_ADD = AW'((1 << FRAC) - 1);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_UPD  = 15'b000000000000010,
        S_DT   = 15'b000000000000100,
        S_REL  = 15'b000000000001000,
        S_ABS  = 15'b000000000010000,
        S_MUL  = 15'b000000000100000,
        S_RND  = 15'b000000001000000,
        S_JNT  = 15'b000000010000000,
        S_DIFF = 15'b000000100000000,
        S_DABS = 15'b000001000000000,
        S_M1   = 15'b000010000000000,
        S_M2   = 15'b000100000000000,
        S_DIV  = 15'b001000000000000,
        S_VEL  = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [ANGLE_BITS-1:0] raw_angle;
        logic                  read_ok;
        logic [TS_W-1:0]       timestamp_ms;
    } t_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_used;
        logic [TURN_W-1:0]     turn_count;
        logic [TOT_W-1:0]      total_counts;
        logic [JNT_W-1:0]      joint_position;
        logic [JNT_W-1:0]      joint_velocity;
        logic                  connected;
    } t_result;

    typedef struct packed {
        logic start;
        logic out_free;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

    typedef struct packed {
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic          sub;
    } t_alu_req;

    // low 32 bits of turns * 4096 + angle
    function automatic logic signed [TOT_W-1:0] total_of(
        input logic signed [TURN_BITS-1:0] t,
        input logic [ANGLE_BITS-1:0]       a
    );
        logic [TOT_W-1:0] w;
        w = TOT_W'(t);
        return $signed({w[TOT_W-ANGLE_BITS-1:0], a});
    endfunction

    // signed saturation of a magnitude and its negation to 48 bits
    function automatic logic [JNT_W-1:0] sat_to_jnt(
        input logic [AW-1:0] mag,
        input logic          neg,
        input logic [AW-1:0] negv
    );
        logic over_p;
        logic over_n;
        over_p = |mag[AW-1:JNT_W-1];
        over_n = (|mag[AW-1:JNT_W]) | (mag[JNT_W-1] & (|mag[JNT_W-2:0]));
        if (neg) begin
            return over_n ? JNT_MIN : negv[JNT_W-1:0];
        end
        return over_p ? JNT_MAX : mag[JNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* design/mtt_alu.sv */
// Shared adder/subtractor used by every arithmetic state of the sequencer but the turn update.
`default_nettype none
module mtt_alu (
    input  mtt_pkg::t_alu_req         i_req,
    output logic [mtt_pkg::AW-1:0]    o_sum
);
    import mtt_pkg::*;

    logic [AW-1:0] w_b;

    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + w_b + AW'(i_req.sub);

endmodule
`default_nettype wire

/* design/mtt_cfg.sv */
// Configuration register file: gear reciprocal and zero preset.
`default_nettype none
module mtt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mtt_pkg::ADDR_W-1:0]     paddr,
    input  logic [mtt_pkg::DATA_W-1:0]     pwdata,
    output logic [mtt_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output logic [mtt_pkg::GEAR_W-1:0]     o_gear,
    output logic signed [mtt_pkg::TOT_W-1:0] o_preset
);
    import mtt_pkg::*;

    logic [GEAR_W-1:0]       r_gear;
    logic signed [TOT_W-1:0] r_preset;
    logic [RIDX_W-1:0]       w_idx;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear   <= GEAR_RESET;
            r_preset <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_GEAR:   r_gear   <= pwdata[GEAR_W-1:0];
                REG_PRESET: r_preset <= $signed(pwdata[TOT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GEAR:   prdata = DATA_W'(r_gear);
            REG_PRESET: prdata = DATA_W'(r_preset);
            default:    prdata = '0;
        endcase
    end

    assign o_gear   = r_gear;
    assign o_preset = r_preset;

endmodule
`default_nettype wire

/* design/mtt_eng.sv */
// Tracker state and the sequencer that drives the shared adder.
`default_nettype none
module mtt_eng (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mtt_pkg::t_eng_ctl                 i_ctl,
    input  mtt_pkg::t_item                    i_item,
    input  logic [mtt_pkg::GEAR_W-1:0]        i_gear,
    input  logic signed [mtt_pkg::TOT_W-1:0]  i_preset,
    output mtt_pkg::t_eng_sts                 o_sts,
    output mtt_pkg::t_result                  o_res
);
    import mtt_pkg::*;

    t_state                      r_state;
    t_item                       r_item;
    logic [ANGLE_BITS-1:0]       r_prev_angle;
    logic signed [TURN_BITS-1:0] r_turns;
    logic signed [TOT_W-1:0]     r_zoff;
    logic signed [JNT_W-1:0]     r_prev_joint;
    logic [TS_W-1:0]             r_prev_time;
    logic signed [JNT_W-1:0]     r_vel;
    logic signed [JNT_W-1:0]     r_joint;
    logic                        r_started;
    logic                        r_link;
    logic                        r_first;
    logic                        r_do_vel;
    logic [TS_W-1:0]             r_dt;
    logic [AW-1:0]               r_x;
    logic [AW-1:0]               r_acc;
    logic                        r_neg;
    logic [CNT_W-1:0]            r_cnt;
    logic [REM_W-1:0]            r_rem;

    t_alu_req                    w_req;
    logic [AW-1:0]               w_sum;
    logic [ANGLE_BITS-1:0]       w_angle;
    logic signed [ANGLE_BITS:0]  w_adiff;
    logic [AW-1:0]               w_qm;
    logic [JNT_W-1:0]            w_jsat;
    logic [JNT_W-1:0]            w_vsat;
    logic [REM_W:0]              w_shift;

    mtt_alu u_alu (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    assign w_angle = r_item.read_ok ? r_item.raw_angle : r_prev_angle;
    assign w_adiff = $signed({1'b0, w_angle}) - $signed({1'b0, r_prev_angle});
    assign w_qm    = AW'(r_acc[FRAC+QM_W-1:FRAC]);
    assign w_shift = {r_rem, r_acc[AW-1]};
    // r_neg clear here means the relative count was positive: joint is negative
    assign w_jsat  = sat_to_jnt(w_qm, !r_neg, w_sum);
    assign w_vsat  = sat_to_jnt(r_acc, r_neg, w_sum);

    always_comb begin
        w_req = '0;
        case (r_state)
            S_DT: begin
                w_req.a   = AW'(r_item.timestamp_ms);
                w_req.b   = AW'(r_prev_time);
                w_req.sub = 1'b1;
            end
            S_REL: begin
                w_req.a   = AW'(total_of(r_turns, r_prev_angle));
                w_req.b   = AW'(r_zoff);
                w_req.sub = 1'b1;
            end
            S_ABS, S_DABS: begin
                w_req.b   = r_x;
                w_req.sub = 1'b1;
            end
            S_MUL: begin
                w_req.a = r_acc << 1;
                w_req.b = i_gear[r_cnt[GIDX_W-1:0]] ? r_x : '0;
            end
            S_RND: begin
                w_req.a = r_acc;
                w_req.b = ROUND_ADD;
            end
            S_JNT: begin
                w_req.b   = w_qm;
                w_req.sub = 1'b1;
            end
            S_DIFF: begin
                w_req.a   = AW'(r_joint);
                w_req.b   = AW'(r_prev_joint);
                w_req.sub = 1'b1;
            end
            S_M1: begin
                w_req.a   = r_x << 10;
                w_req.b   = r_x << 4;
                w_req.sub = 1'b1;
            end
            S_M2: begin
                w_req.a   = r_acc;
                w_req.b   = r_x << 3;
                w_req.sub = 1'b1;
            end
            S_DIV: begin
                w_req.a   = AW'(w_shift);
                w_req.b   = AW'(r_dt);
                w_req.sub = 1'b1;
            end
            S_VEL: begin
                w_req.b   = r_acc;
                w_req.sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_angle <= '0;
            r_turns      <= '0;
            r_zoff       <= '0;
            r_prev_joint <= '0;
            r_prev_time  <= '0;
            r_vel        <= '0;
            r_joint      <= '0;
            r_started    <= 1'b0;
            r_link       <= 1'b0;
            r_first      <= 1'b0;
            r_do_vel     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_item  <= i_item;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_first  <= (r_item.operation == OP_SAMPLE) && !r_started;
                    r_do_vel <= 1'b0;
                    r_state  <= ((r_item.operation == OP_SAMPLE) && r_started) ? S_DT : S_REL;
                    case (r_item.operation)
                        OP_SAMPLE: begin
                            r_link       <= r_item.read_ok;
                            r_prev_angle <= w_angle;
                            if (!r_started) begin
                                r_turns     <= '0;
                                r_started   <= 1'b1;
                                r_prev_time <= r_item.timestamp_ms;
                            end else begin
                                if (w_adiff < -HALF_TURN) begin
                                    if (r_turns != TURN_MAX) r_turns <= r_turns + 1'b1;
                                end else if (w_adiff > HALF_TURN) begin
                                    if (r_turns != TURN_MIN) r_turns <= r_turns - 1'b1;
                                end
                            end
                        end
                        OP_CAPTURE: r_zoff <= total_of(r_turns, r_prev_angle);
                        OP_LOAD:    r_zoff <= i_preset;
                        default: ;
                    endcase
                end
                S_DT: begin
                    r_dt     <= w_sum[TS_W-1:0];
                    r_do_vel <= |w_sum[TS_W-1:0];
                    r_state  <= S_REL;
                end
                S_REL: begin
                    r_x     <= w_sum;
                    r_neg   <= w_sum[AW-1];
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    if (r_neg) r_x <= w_sum;
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(GEAR_W - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= w_sum;
                    if (r_cnt == '0) begin
                        r_state <= S_RND;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_RND: begin
                    if (!r_neg) r_acc <= w_sum;
                    r_state <= S_JNT;
                end
                S_JNT: begin
                    r_joint <= $signed(w_jsat);
                    if (r_first) begin
                        r_prev_joint <= $signed(w_jsat);
                        r_state      <= S_DONE;
                    end else if (r_do_vel) begin
                        r_state <= S_DIFF;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIFF: begin
                    r_x     <= w_sum;
                    r_neg   <= w_sum[AW-1];
                    r_state <= S_DABS;
                end
                S_DABS: begin
                    if (r_neg) r_x <= w_sum;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= w_sum;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= w_sum;
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(AW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_sum[AW-1] ? w_shift[REM_W-1:0] : w_sum[REM_W-1:0];
                    r_acc <= {r_acc[AW-2:0], !w_sum[AW-1]};
                    if (r_cnt == '0) begin
                        r_state <= S_VEL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_VEL: begin
                    r_vel        <= $signed(w_vsat);
                    r_prev_joint <= r_joint;
                    r_prev_time  <= r_item.timestamp_ms;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (i_ctl.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE) && i_ctl.out_free;

    assign o_res.angle_used     = r_prev_angle;
    assign o_res.turn_count     = TURN_W'(r_turns);
    assign o_res.total_counts   = total_of(r_turns, r_prev_angle);
    assign o_res.joint_position = r_joint;
    assign o_res.joint_velocity = r_vel;
    assign o_res.connected      = r_link;

endmodule
`default_nettype wire

/* design/multiturn_angle_tracker.sv */
// Top level of the multiturn angle tracker: stream ports, output register, config port.
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: raw_angle, read_ok, timestamp_ms; tuser: operation
// m_axis    out  tvalid/tready           tdata: angle_used .. connected
// apb       in   psel/penable/pready     gear_reciprocal @0x0, zero_preset @0x4
//
// One word at a time; tready is high only while the sequencer is idle.
// Capture, load, the spare code and a first sample run the 24-step shift-add multiply
// through the shared adder; a later sample also passes the time difference state, and one
// with nonzero elapsed time then runs the 58-step restoring divide for its velocity.
// The finished word sits in the output register, so the next word is taken while it waits.
// Reset is synchronous, active low; it zeroes the tracking state and preset and sets the gear to 65536.
`default_nettype none
module multiturn_angle_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_angle [11:0], read_ok [12], timestamp_ms [44:13], zero [47:45]
    input  logic [mtt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation [1:0]
    input  logic [mtt_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // angle_used [11:0], turn_count [31:12], total_counts [63:32],
    // joint_position [111:64], joint_velocity [159:112], connected [160], zero [167:161]
    output logic [mtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mtt_pkg::ADDR_W-1:0]         paddr,
    input  logic [mtt_pkg::DATA_W-1:0]         pwdata,
    output logic [mtt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import mtt_pkg::*;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    t_eng_ctl                 w_ctl;
    t_eng_sts                 w_sts;
    t_item                    w_item;
    t_result                  w_res;
    logic [GEAR_W-1:0]        w_gear;
    logic signed [TOT_W-1:0]  w_preset;

    mtt_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_gear   (w_gear),
        .o_preset (w_preset)
    );

    assign w_item.operation    = s_axis_tuser[OP_W-1:0];
    assign w_item.raw_angle    = s_axis_tdata[ANGLE_BITS-1:0];
    assign w_item.read_ok      = s_axis_tdata[ANGLE_BITS];
    assign w_item.timestamp_ms = s_axis_tdata[ANGLE_BITS+TS_W:ANGLE_BITS+1];

    assign s_axis_tready = w_sts.idle;
    assign w_ctl.start    = s_axis_tvalid && w_sts.idle;
    assign w_ctl.out_free = !r_out_valid || m_axis_tready;

    mtt_eng u_eng (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_item   (w_item),
        .i_gear   (w_gear),
        .i_preset (w_preset),
        .o_sts    (w_sts),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            r_out_data <= OUT_DATA_W'({w_res.connected, w_res.joint_velocity,
                                       w_res.joint_position, w_res.total_counts,
                                       w_res.turn_count, w_res.angle_used});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while sequencer busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (!r_out_valid || m_axis_tready))
        else $error("result overwrote a pending word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the multiturn angle tracker: stream traffic, APB setup, scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import mtt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int     HALF        = 1 << (ANGLE_BITS - 1);
    localparam longint T_HI        = (longint'(1) <<< (TURN_BITS - 1)) - 1;
    localparam longint J_HI        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint J_LO        = -J_HI - 1;
    localparam int     QUIET_LIMIT = 4000;

    class tracker_scoreboard;
        logic [GEAR_W-1:0]     gear;
        longint                preset;
        logic [ANGLE_BITS-1:0] last_angle;
        longint                turns;
        longint                zero_ofs;
        longint                last_joint;
        longint                vel_held;
        logic [TS_W-1:0]       last_ms;
        bit                    primed;
        bit                    link;
        t_result               readouts[$];
        int                    mismatches;

        function new();
            gear       = GEAR_RESET;
            preset     = 0;
            last_angle = '0;
            turns      = 0;
            zero_ofs   = 0;
            last_joint = 0;
            vel_held   = 0;
            last_ms    = '0;
            primed     = 1'b0;
            link       = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [RIDX_W-1:0] idx, logic [DATA_W-1:0] v);
            if (idx == REG_GEAR) begin
                gear = v[GEAR_W-1:0];
            end else if (idx == REG_PRESET) begin
                preset = longint'($signed(v));
            end
        endfunction

        function longint clamp48(longint v);
            if (v > J_HI) return J_HI;
            if (v < J_LO) return J_LO;
            return v;
        endfunction

        // turns * 4096 + angle, wrapped to 32 bits
        function longint motor_total(longint t, logic [ANGLE_BITS-1:0] a);
            logic [63:0] u;
            u = (t <<< ANGLE_BITS) + a;
            return longint'($signed(u[TOT_W-1:0]));
        endfunction

        // arithmetic shift floors towards minus infinity
        function longint joint_at(longint total);
            longint g;
            longint p;
            g = gear;
            p = -((total - zero_ofs) * g);
            return clamp48(p >>> FRAC);
        endfunction

        function void track_input(logic [OP_W-1:0] op, logic [ANGLE_BITS-1:0] raw,
                                  logic ok, logic [TS_W-1:0] ms);
            logic [ANGLE_BITS-1:0] ang;
            logic [TS_W-1:0]       dt;
            int                    diff;
            longint                j;
            longint                span;
            longint                tot;
            t_result               r;
            case (op)
                OP_CAPTURE: begin
                    zero_ofs = motor_total(turns, last_angle);
                end
                OP_LOAD: begin
                    zero_ofs = preset;
                end
                OP_SAMPLE: begin
                    ang  = ok ? raw : last_angle;
                    link = ok;
                    if (!primed) begin
                        last_angle = ang;
                        turns      = 0;
                        last_joint = joint_at(motor_total(0, ang));
                        last_ms    = ms;
                        primed     = 1'b1;
                    end else begin
                        diff = int'(ang) - int'(last_angle);
                        if (diff < -HALF) begin
                            if (turns < T_HI) turns++;
                        end else if (diff > HALF) begin
                            if (turns > -T_HI - 1) turns--;
                        end
                        last_angle = ang;
                        dt = ms - last_ms;
                        if (dt != 0) begin
                            j          = joint_at(motor_total(turns, ang));
                            span       = dt;
                            vel_held   = clamp48(((j - last_joint) * 1000) / span);
                            last_joint = j;
                            last_ms    = ms;
                        end
                    end
                end
                default: begin
                end
            endcase
            tot              = motor_total(turns, last_angle);
            j                = joint_at(tot);
            r.angle_used     = last_angle;
            r.turn_count     = turns[TURN_W-1:0];
            r.total_counts   = tot[TOT_W-1:0];
            r.joint_position = j[JNT_W-1:0];
            r.joint_velocity = vel_held[JNT_W-1:0];
            r.connected      = link;
            readouts.push_back(r);
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on %s: expected %h, got %h", what, want, got);
                end
            end
        endfunction

        function void check_output(logic [OUT_DATA_W-1:0] w);
            t_result want;
            t_result got;
            got.angle_used     = w[11:0];
            got.turn_count     = w[31:12];
            got.total_counts   = w[63:32];
            got.joint_position = w[111:64];
            got.joint_velocity = w[159:112];
            got.connected      = w[160];
            if (readouts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("output word with none expected: %h", w);
                return;
            end
            want = readouts.pop_front();
            compare("angle_used", 64'(want.angle_used), 64'(got.angle_used));
            compare("turn_count", 64'(want.turn_count), 64'(got.turn_count));
            compare("total_counts", 64'(want.total_counts), 64'(got.total_counts));
            compare("joint_position", 64'(want.joint_position), 64'(got.joint_position));
            compare("joint_velocity", 64'(want.joint_velocity), 64'(got.joint_velocity));
            compare("connected", 64'(want.connected), 64'(got.connected));
        endfunction

        function bit busy();
            return readouts.size() != 0;
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [DATA_W-1:0]     pwdata        = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    tracker_scoreboard sb = new();
    bit                calm = 1'b0;
    int                quiet_cycles = 0;

    multiturn_angle_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [ANGLE_BITS-1:0] raw,
                             input logic ok, input logic [TS_W-1:0] ms);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 100);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ms, ok, raw};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.track_input(op, raw, ok, ms);
    endtask

    // hold the sender until every word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.busy()) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [ANGLE_BITS-1:0] shaft;
        logic [TS_W-1:0]       now_ms;
        logic [TS_W-1:0]       dt;
        int                    pick;
        int                    roll;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before the first sample, then first-sample setup and turn boundaries
        send_word(OP_SPARE, 12'hABC, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_CAPTURE, 12'h000, 1'b0, 32'h0000_0000);
        send_word(OP_SAMPLE, 12'hFFF, 1'b1, 32'hFFFF_FFF0);
        send_word(OP_SAMPLE, 12'h000, 1'b1, 32'h0000_0004);
        send_word(OP_SAMPLE, 12'd2000, 1'b0, 32'h0000_0004);
        send_word(OP_SAMPLE, 12'd2048, 1'b1, 32'h0000_0005);
        send_word(OP_SAMPLE, 12'd0, 1'b1, 32'h0000_0006);
        send_word(OP_SAMPLE, 12'd2049, 1'b1, 32'd1006);
        send_word(OP_SAMPLE, 12'd0, 1'b1, 32'd1007);
        send_word(OP_CAPTURE, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_SAMPLE, 12'd100, 1'b1, 32'd1007);
        send_word(OP_LOAD, 12'hFFF, 1'b1, 32'hFFFF_FFFF);

        // position and velocity saturation
        drain();
        apb_write(REG_GEAR, 32'h00FF_FFFF);
        apb_write(REG_PRESET, 32'h7FFF_FFFF);
        send_word(OP_LOAD, 12'h000, 1'b0, 32'h0);
        send_word(OP_SAMPLE, 12'hFFF, 1'b1, 32'd1008);
        drain();
        apb_write(REG_PRESET, 32'h8000_0000);
        send_word(OP_LOAD, 12'h000, 1'b0, 32'h0);
        send_word(OP_SAMPLE, 12'hFFF, 1'b1, 32'd1009);
        send_word(OP_SAMPLE, 12'h000, 1'b1, 32'd1010);

        // zero gear, then the smallest
        drain();
        apb_write(REG_GEAR, 32'h0);
        send_word(OP_SAMPLE, 12'd3000, 1'b1, 32'd1011);
        drain();
        apb_write(REG_GEAR, 32'h1);
        send_word(OP_SAMPLE, 12'd3100, 1'b1, 32'd1100);
        send_word(OP_SPARE, 12'h555, 1'b0, 32'h5555_5555);

        shaft  = 12'd3100;
        now_ms = 32'd1100;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    apb_write(REG_GEAR, 32'h00FF_FFFF);
                    apb_write(REG_PRESET, 32'h7FFF_FFFF);
                end
                1: begin
                    apb_write(REG_GEAR, 32'h1);
                    apb_write(REG_PRESET, 32'h8000_0000);
                end
                2: begin
                    apb_write(REG_GEAR, $urandom_range(1, 32'h00FF_FFFF));
                    apb_write(REG_PRESET, $urandom);
                end
                3: begin
                    apb_write(REG_GEAR, 32'(GEAR_RESET));
                    apb_write(REG_PRESET, 32'h0);
                end
                4: begin
                    apb_write(REG_GEAR, $urandom_range(1, 4096));
                    apb_write(REG_PRESET, $urandom);
                end
                default: begin
                    apb_write(REG_GEAR, $urandom);
                    apb_write(REG_PRESET, $urandom);
                end
            endcase
            calm = (ph == 3);
            for (int n = 0; n < 255; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    if (pick == 0) drain();
                    if ($urandom_range(0, 9) == 0) begin
                        shaft = 12'($urandom);
                    end else begin
                        shaft = shaft + 12'($urandom_range(0, 1200) - 600);
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 15) begin
                        dt = 0;
                    end else if (roll < 65) begin
                        dt = $urandom_range(1, 20);
                    end else if (roll < 90) begin
                        dt = $urandom_range(21, 2000);
                    end else begin
                        dt = $urandom;
                    end
                    now_ms = now_ms + dt;
                    send_word(OP_SAMPLE, shaft, $urandom_range(0, 99) < 92, now_ms);
                end else if (pick < 80) begin
                    send_word(OP_SAMPLE, 12'($urandom), 1'($urandom), $urandom);
                end else if (pick < 88) begin
                    send_word(OP_CAPTURE, 12'($urandom), 1'($urandom), $urandom);
                end else if (pick < 95) begin
                    send_word(OP_LOAD, 12'($urandom), 1'($urandom), $urandom);
                end else begin
                    send_word(OP_SPARE, 12'($urandom), 1'($urandom), $urandom);
                end
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (sb.busy()) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
